// ===== src/bcwe_pkg.sv =====
// ----------------------------------------------------------------------------
// Beacon clock warp estimator package
// Shared widths, reset values, register indexes, sequencer states and the
// control bundle of the shared divider.
// ----------------------------------------------------------------------------
package bcwe_pkg;

  // Field and register widths
  localparam int TIME_W  = 63;
  localparam int CFG_W   = 32;
  localparam int ALPHA_W = 16;
  localparam int WARP_W  = 32;
  localparam int FRAC_W  = 30;

  // Shared divider widths: 64-bit divisor, numerator carries 30 fraction bits
  localparam int DEN_W  = 64;
  localparam int NUM_W  = DEN_W + FRAC_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  // Multiplier operand and product widths
  localparam int MULA_W = ALPHA_W + 1;
  localparam int PROD_W = MULA_W + WARP_W;
  localparam int SUM_W  = PROD_W + 1;

  // Default ring depth
  localparam int RING_DEPTH_DEF = 8;

  // Reset values
  localparam logic [CFG_W-1:0]   MIN_SPACING_RST = 32'd1;
  localparam logic [CFG_W-1:0]   PERIOD_RST      = 32'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = 16'd58982;
  localparam logic [WARP_W-1:0]  WARP_ONE        = 32'h4000_0000;

  // EMA constants
  localparam logic [MULA_W-1:0] ALPHA_FULL = 17'h1_0000;
  localparam logic [SUM_W-1:0]  EMA_ROUND  = 50'd32768;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SPACING = 2'd0,
    CFG_PERIOD      = 2'd1,
    CFG_ALPHA       = 2'd2
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPAN,
    ST_LOAD_RND,
    ST_DIV_RND,
    ST_LOAD_RATIO,
    ST_DIV_RATIO,
    ST_EMA_MUL0,
    ST_EMA_MUL1,
    ST_EMA_SUM,
    ST_DONE
  } state_t;

  // Divider control bundle
  typedef struct packed {
    logic              load;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

endpackage

// ===== src/bcwe_divider.sv =====
// ----------------------------------------------------------------------------
// Shared restoring divider
// Shifts the numerator in MSB first, one quotient bit per cycle, for a
// programmable number of steps. Keeps the remainder and the low quotient bits.
// ----------------------------------------------------------------------------
module bcwe_divider
  import bcwe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctrl_t         ctrl,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]  den_in,
  output logic              busy,
  output logic [WARP_W-1:0] quo,
  output logic [DEN_W-1:0]  rem
);

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [WARP_W-1:0] quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;

  logic [DEN_W:0]    trial;
  logic              fits;

  // Form the trial remainder for this step
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  // Control: load, count down, drop busy after the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.load) begin
      busy_r <= 1'b1;
      cnt_r  <= ctrl.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: subtract when the divisor fits, shift in the quotient bit
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num_r <= num_in;
      den_r <= den_in;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      if (fits) begin
        rem_r <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[DEN_W-1:0];
      end
      quo_r <= {quo_r[WARP_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== src/beacon_clock_warp_estimator.sv =====
// Sequence: a dropped beacon, or one stored with the ring not yet full or a zero
// period, goes from the check state straight to the result; a span that rounds to zero
// periods ends after the rounding division, and a full update runs the shared
// 1-bit-per-cycle divider for 64 rounding steps, then 94 ratio steps, then the EMA.
// Throughput: one transaction at a time; the next is taken once the result leaves (out_stall low).
// Reset (synchronous) empties the ring via its valid bits, sets warp to one and defaults.
// ----------------------------------------------------------------------------
// Beacon clock warp estimator
// Stores spaced beacon timestamps in a ring and, once full, folds the ratio of
// measured to nominal span into a moving average warp factor (Q2.30).
// ----------------------------------------------------------------------------
module beacon_clock_warp_estimator
  import bcwe_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_W-1:0]    in_beacon_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_accepted,
  output logic                 out_updated,
  output logic [WARP_W-1:0]    out_warp_value
);

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

  // Configuration registers
  logic [CFG_W-1:0]   min_spacing_r;
  logic [CFG_W-1:0]   period_r;
  logic [ALPHA_W-1:0] alpha_r;

  // Sequencer and ring state
  state_t             state_r, state_nxt;
  logic [TIME_W-1:0]  ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_r;
  logic [SLOT_W-1:0]  ws_r;
  logic [SLOT_W-1:0]  prev_slot, next_slot, rd_addr;
  logic [TIME_W-1:0]  rd_r;
  logic [TIME_W-1:0]  t_r;

  // Arithmetic registers
  logic [DEN_W-1:0]   span_r;
  logic [DEN_W-1:0]   dividend_r;
  logic [PROD_W-1:0]  mul_r;
  logic [PROD_W-1:0]  acc_r;
  logic [WARP_W-1:0]  warp_r;
  logic               accepted_r;
  logic               updated_r;

  // Control strobes
  logic               in_take;
  logic               mem_we;
  logic               beacon_ok;
  logic               do_update;
  logic               n_nonzero;
  logic [DEN_W-1:0]   dividend;
  logic [TIME_W-1:0]  gap;

  // Divider interface
  div_ctrl_t          div_ctrl;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_busy;
  logic [WARP_W-1:0]  div_quo;
  logic [DEN_W-1:0]   div_rem;

  // Shared multiplier operands
  logic [MULA_W-1:0]  mul_a;
  logic [WARP_W-1:0]  mul_b;
  logic [SUM_W-1:0]   ema_sum;

  // Ring slot neighbors
  assign prev_slot = (ws_r == '0) ? SLOT_LAST : ws_r - SLOT_W'(1);
  assign next_slot = (ws_r == SLOT_LAST) ? '0 : ws_r + SLOT_W'(1);
  assign rd_addr   = (state_r == ST_CHECK) ? next_slot : prev_slot;

  // Spacing check against the previous stored beacon
  assign gap       = t_r - rd_r;
  assign beacon_ok = !valid_r[prev_slot] ||
                     ((t_r >= rd_r) && ({1'b0, gap} >= {32'd0, min_spacing_r}));
  assign do_update = valid_r[next_slot] && (period_r != '0);

  // Rounding terms
  assign dividend  = span_r + {33'd0, period_r[CFG_W-1:1]};
  assign n_nonzero = (dividend_r >= {32'd0, period_r});

  // EMA terms
  assign ema_sum   = SUM_W'(acc_r) + SUM_W'(mul_r) + EMA_ROUND;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_spacing_r <= MIN_SPACING_RST;
      period_r      <= PERIOD_RST;
      alpha_r       <= ALPHA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_SPACING: min_spacing_r <= cfg_data;
        CFG_PERIOD:      period_r      <= cfg_data;
        CFG_ALPHA:       alpha_r       <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (beacon_ok && do_update) state_nxt = ST_SPAN;
        else                        state_nxt = ST_DONE;
      end
      ST_SPAN:       state_nxt = ST_LOAD_RND;
      ST_LOAD_RND:   state_nxt = ST_DIV_RND;
      ST_DIV_RND:    if (!div_busy) state_nxt = ST_LOAD_RATIO;
      ST_LOAD_RATIO: state_nxt = n_nonzero ? ST_DIV_RATIO : ST_DONE;
      ST_DIV_RATIO:  if (!div_busy) state_nxt = ST_EMA_MUL0;
      ST_EMA_MUL0:   state_nxt = ST_EMA_MUL1;
      ST_EMA_MUL1:   state_nxt = ST_EMA_SUM;
      ST_EMA_SUM:    state_nxt = ST_DONE;
      ST_DONE:       if (!out_stall) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and strobes
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    mem_we    = 1'b0;
    div_ctrl  = '{load: 1'b0, steps: '0};
    div_num   = {dividend, {FRAC_W{1'b0}}};
    div_den   = {32'd0, period_r};
    mul_a     = {1'b0, alpha_r};
    mul_b     = warp_r;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_CHECK: mem_we   = beacon_ok;
      ST_LOAD_RND: begin
        div_ctrl = '{load: 1'b1, steps: STEP_W'(DEN_W)};
      end
      ST_LOAD_RATIO: begin
        div_ctrl = '{load: n_nonzero, steps: STEP_W'(NUM_W)};
        div_num  = {span_r, {FRAC_W{1'b0}}};
        div_den  = dividend_r - div_rem;
      end
      ST_EMA_MUL1: begin
        mul_a = ALPHA_FULL - {1'b0, alpha_r};
        mul_b = div_quo;
      end
      ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ring memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[ws_r] <= t_r;
    end
    rd_r <= ring_mem[rd_addr];
  end

  // Ring control: valid bits and write slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ws_r    <= '0;
    end else if (mem_we) begin
      valid_r[ws_r] <= 1'b1;
      ws_r          <= next_slot;
    end
  end

  // Warp estimate and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warp_r     <= WARP_ONE;
      accepted_r <= 1'b0;
      updated_r  <= 1'b0;
    end else begin
      if (state_r == ST_CHECK) begin
        accepted_r <= beacon_ok;
        updated_r  <= 1'b0;
      end
      if (state_r == ST_EMA_SUM) begin
        warp_r    <= ema_sum[ALPHA_W +: WARP_W];
        updated_r <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      t_r <= in_beacon_time;
    end
    if (state_r == ST_SPAN) begin
      span_r <= {1'b0, t_r} - {1'b0, rd_r};
    end
    if (state_r == ST_LOAD_RND) begin
      dividend_r <= dividend;
    end
    if (state_r == ST_EMA_MUL0 || state_r == ST_EMA_MUL1) begin
      mul_r <= mul_a * mul_b;
    end
    if (state_r == ST_EMA_MUL1) begin
      acc_r <= mul_r;
    end
  end

  // Shared divider
  bcwe_divider u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (div_ctrl),
    .num_in (div_num),
    .den_in (div_den),
    .busy   (div_busy),
    .quo    (div_quo),
    .rem    (div_rem)
  );

  assign out_accepted   = accepted_r;
  assign out_updated    = updated_r;
  assign out_warp_value = warp_r;

endmodule
